// ===== rtl/core/spbec_pkg.sv =====
package spbec_pkg;

  // Memory geometry under test
  localparam int NUM_BLOCKS        = 17;
  localparam int ROWS_PER_COLUMN   = 256;
  localparam int COLUMNS_PER_BLOCK = 16;

  localparam int ROW_W = $clog2(ROWS_PER_COLUMN);
  localparam int COL_W = (COLUMNS_PER_BLOCK > 1) ? $clog2(COLUMNS_PER_BLOCK) : 1;

  // Field widths fixed by the interface
  localparam int BYTE_W  = 8;
  localparam int BLK_W   = 5;
  localparam int COUNT_W = 15;
  localparam int POP_W   = 4;

  localparam logic [BYTE_W-1:0]  ALT_PATTERN  = 8'hA5;
  localparam logic [BYTE_W-1:0]  ALT_EVEN_ROW = 8'h5A;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 15'h7FFF;

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS_PER_COLUMN - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS_PER_BLOCK - 1);
  localparam logic [BLK_W-1:0] LAST_BLK  = BLK_W'(NUM_BLOCKS - 1);

  // Largest count one block can reach, saturation included
  localparam int BLOCK_ERR_RAW  = BYTE_W * (ROWS_PER_COLUMN - 1) * COLUMNS_PER_BLOCK;
  localparam int BLOCK_ERR_MAX  = (BLOCK_ERR_RAW > 32767) ? 32767 : BLOCK_ERR_RAW;

  // Queue depths (power of two, pointers wrap naturally)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              present;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]   block_index;
    logic [COUNT_W-1:0] error_count;
    logic               last_block;
  } out_item_t;

  // Classified beat handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] mismatch;
    logic              end_of_block;
    logic [BLK_W-1:0]  block_index;
    logic              last_block;
  } work_t;

endpackage

// ===== rtl/core/spbec_front.sv =====
module spbec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 push,
  input  spbec_pkg::in_item_t  item,
  output logic                 full,
  input  logic                 q_full,
  output logic                 q_push,
  output spbec_pkg::work_t     q_item
);
  import spbec_pkg::*;

  logic [BYTE_W-1:0] pattern;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [BLK_W-1:0]  blk;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [BLK_W-1:0]  blk_next;
  logic [BYTE_W-1:0] data;
  logic [BYTE_W-1:0] expect_byte;
  logic              skip_row;
  logic              end_blk;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_comb begin
    data        = item.present ? item.data_byte : '0;
    expect_byte = pattern;
    if (pattern == ALT_PATTERN && !row[0]) begin
      expect_byte = ALT_EVEN_ROW;
    end
    skip_row = (row == LAST_ROW);
    end_blk  = skip_row && (col == LAST_COL);

    q_item.mismatch     = skip_row ? '0 : (data ^ expect_byte);
    q_item.end_of_block = end_blk;
    q_item.block_index  = blk;
    q_item.last_block   = (blk == LAST_BLK);
  end

  assign q_push = accept;

  // Advance row, then column, then block
  always_comb begin
    row_next = row;
    col_next = col;
    blk_next = blk;
    if (accept) begin
      if (skip_row) begin
        row_next = '0;
        if (col == LAST_COL) begin
          col_next = '0;
          blk_next = (blk == LAST_BLK) ? '0 : blk + BLK_W'(1);
        end else begin
          col_next = col + COL_W'(1);
        end
      end else begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      row     <= '0;
      col     <= '0;
      blk     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern <= cfg_data;
      end
      row <= row_next;
      col <= col_next;
      blk <= blk_next;
    end
  end

endmodule

// ===== rtl/core/spbec_queue.sv =====
module spbec_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spbec_pkg::work_t  push_item,
  output logic              full,
  input  logic              pop,
  output spbec_pkg::work_t  head_item,
  output logic              empty
);
  import spbec_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/spbec_back.sv =====
module spbec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wq_empty,
  input  spbec_pkg::work_t     wq_item,
  output logic                 wq_pop,
  output logic                 empty,
  input  logic                 pop,
  output spbec_pkg::out_item_t result
);
  import spbec_pkg::*;

  logic [COUNT_W-1:0] acc;
  logic [COUNT_W-1:0] acc_next;
  logic [POP_W-1:0]   ones;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;
  out_item_t          res_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               res_full;
  logic               res_push;
  logic               res_pop;
  out_item_t          res_item;

  assign res_full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign res_pop  = pop && !empty;
  assign result   = res_q[rd_ptr];

  // Hold a block-end beat until the result queue has room
  assign wq_pop   = !wq_empty && (!wq_item.end_of_block || !res_full);
  assign res_push = wq_pop && wq_item.end_of_block;

  always_comb begin
    ones = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      ones = ones + POP_W'(wq_item.mismatch[i]);
    end
    sum = {1'b0, acc} + (COUNT_W + 1)'(ones);
    sat = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    acc_next = acc;
    if (wq_pop) begin
      acc_next = wq_item.end_of_block ? '0 : sat;
    end
    res_item.block_index = wq_item.block_index;
    res_item.error_count = sat;
    res_item.last_block  = wq_item.last_block;
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[wr_ptr] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      acc <= acc_next;
      if (res_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (res_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (res_push && !res_pop) begin
        count <= count + QCNT_W'(1);
      end else if (res_pop && !res_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sram_pattern_bit_error_counter_unit.sv =====
// A block's count reaches the result ports after its last byte beat passes both queues.
// Throughput: one byte per cycle via popcount/accumulate while the work queue has room.
// A two-entry work queue and a two-entry result queue let input and output stall apart.
// Reset (rst, synchronous, active high): position, block index and count go to zero,
// pattern to 0x00, and both queues empty.
module sram_pattern_bit_error_counter_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 push,
  input  spbec_pkg::in_item_t  item,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output spbec_pkg::out_item_t result
);
  import spbec_pkg::*;

  // Front to work queue
  logic  fq_push;
  work_t fq_item;
  logic  wq_full;
  // Work queue to back
  work_t wq_item;
  logic  wq_empty;
  logic  wq_pop;

  // Front: track row/column/block position, pick the expected byte,
  // drop the last row of every column, flag the block end.
  spbec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .q_full    (wq_full),
    .q_push    (fq_push),
    .q_item    (fq_item)
  );

  // Short queue that decouples classification from counting
  spbec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (wq_full),
    .pop       (wq_pop),
    .head_item (wq_item),
    .empty     (wq_empty)
  );

  // Back: popcount each mismatch beat, accumulate with saturation,
  // and queue one result beat per finished block.
  spbec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wq_empty (wq_empty),
    .wq_item  (wq_item),
    .wq_pop   (wq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // Both queues come out of reset empty
  a_reset_empty : assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The final-block flag agrees with the reported block index
  a_last_flag : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_block == (result.block_index == LAST_BLK)))
    else $error("last_block does not match block_index");

  // No block can report more errors than its compared bits
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (int'(result.error_count) <= BLOCK_ERR_MAX))
    else $error("error_count above block maximum");

  // The back consumes only beats that are present
  a_pop_valid : assert property (@(posedge clk) disable iff (rst)
    wq_pop |-> !wq_empty)
    else $error("work queue popped while empty");

endmodule
